### src/tped_pkg.sv
// types and constants shared by the tracker pattern event decoder
`timescale 1ns / 1ps

package tped_pkg;

  // parser phase within the packed stream
  typedef enum logic [2:0] {
    PH_ROW   = 3'd0,
    PH_CHAN  = 3'd1,
    PH_NOTE  = 3'd2,
    PH_FX    = 3'd3,
    PH_PARAM = 3'd4,
    PH_IDLE  = 3'd5
  } phase_e;

  // effect nibbles of the packed stream
  localparam logic [3:0] FX_NIB_NONE      = 4'd0;
  localparam logic [3:0] FX_NIB_SLIDE_UP  = 4'd1;
  localparam logic [3:0] FX_NIB_SLIDE_DN  = 4'd2;
  localparam logic [3:0] FX_NIB_TONEPORTA = 4'd3;
  localparam logic [3:0] FX_NIB_TP_VOL    = 4'd5;
  localparam logic [3:0] FX_NIB_VOLSLIDE  = 4'd10;
  localparam logic [3:0] FX_NIB_SETVOL    = 4'd12;
  localparam logic [3:0] FX_NIB_BREAK     = 4'd13;
  localparam logic [3:0] FX_NIB_SPEED     = 4'd15;

  // remapped effect codes on the result side
  localparam logic [3:0] FX_NONE      = 4'd0;
  localparam logic [3:0] FX_SLIDE_UP  = 4'd1;
  localparam logic [3:0] FX_SLIDE_DN  = 4'd2;
  localparam logic [3:0] FX_TONEPORTA = 4'd3;
  localparam logic [3:0] FX_TP_VOL    = 4'd4;
  localparam logic [3:0] FX_VOLSLIDE  = 4'd5;
  localparam logic [3:0] FX_SETVOL    = 4'd6;
  localparam logic [3:0] FX_BREAK     = 4'd7;
  localparam logic [3:0] FX_SPEED     = 4'd8;

  // note nibble codes
  localparam logic [3:0] NOTE_NIB_LAST   = 4'd12;
  localparam logic [3:0] NOTE_NIB_KEYOFF = 4'd15;
  localparam logic [6:0] SEMITONES       = 7'd12;

  // parameter range limits
  localparam logic [7:0] SLIDE_SPLIT = 8'd50;
  localparam logic [7:0] SLIDE_TOP   = 8'd100;
  localparam logic [7:0] NIBBLE_MAX  = 8'd15;
  localparam logic [7:0] VALUE63_MAX = 8'd63;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       first_byte;
    logic [4:0] pattern_in;
  } in_item_t;

  typedef struct packed {
    logic [4:0] pattern_out;
    logic [5:0] row;
    logic [3:0] track;
    logic [6:0] note;
    logic       key_off;
    logic [4:0] instrument;
    logic [3:0] effect_code;
    logic [7:0] effect_value;
    logic [3:0] effect2_code;
    logic [3:0] effect2_value;
    logic       event_kept;
    logic       pattern_end;
  } out_item_t;

  // clamp to a nibble
  function automatic logic [3:0] min15(input logic [7:0] v);
    min15 = (v < NIBBLE_MAX) ? v[3:0] : NIBBLE_MAX[3:0];
  endfunction

endpackage

### src/tped_stream_if.sv
// valid/ready stream channel carrying one item per handshake
`timescale 1ns / 1ps

interface tped_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/tracker_pattern_event_decoder_core.sv
// tracker pattern event decoder top level: byte parser and event mapping
`timescale 1ns / 1ps

// Takes a packed pattern stream one byte per cycle and gives one event item
// after the last byte of each event (effect byte, or parameter byte when the
// effect nibble is nonzero). The parser state registers feed a short mapping
// path into a single output register, so an event item is visible the cycle
// after its last byte is accepted. Input ready stays high every cycle unless
// that output register holds an item the sink has not taken, so the block
// sustains one byte per cycle while the sink keeps up. A byte with first_byte
// set restarts parsing at a row byte of the given pattern; after the last
// event of the last row, bytes are dropped until the next first_byte.
module tracker_pattern_event_decoder_core
  import tped_pkg::*;
#(
  parameter int CHANNEL_LIMIT = 9,
  parameter int PATTERN_COUNT = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tped_stream_if.sink   in_i,
  tped_stream_if.source out_o
);

  phase_e     phase_q, phase_d;
  logic [4:0] pattern_q, pattern_d;
  logic [5:0] row_q, row_d;
  logic       row_last_q, row_last_d;
  logic [7:0] chan_q, chan_d;
  logic [7:0] note_q, note_d;
  logic [7:0] fx_q, fx_d;

  out_item_t  out_q, out_d;
  logic       out_valid_q, out_valid_d;

  in_item_t   in_item;
  logic       in_acc;
  logic       emit;
  phase_e     cur_phase;
  logic [7:0] fx_byte;
  logic [7:0] param;
  out_item_t  ev;

  assign in_item  = in_i.payload;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc   = in_i.valid && in_i.ready;

  // parser: next state and emit strobe
  always_comb begin
    cur_phase = in_item.first_byte ? PH_ROW : phase_q;
    pattern_d = in_item.first_byte ? in_item.pattern_in : pattern_q;
    phase_d   = cur_phase;
    row_d     = row_q;
    row_last_d = row_last_q;
    chan_d    = chan_q;
    note_d    = note_q;
    fx_d      = fx_q;
    emit      = 1'b0;
    fx_byte   = fx_q;
    param     = 8'd0;
    unique case (cur_phase)
      PH_ROW: begin
        row_d      = in_item.byte_in[5:0];
        row_last_d = in_item.byte_in[7];
        phase_d    = PH_CHAN;
      end
      PH_CHAN: begin
        chan_d  = in_item.byte_in;
        phase_d = PH_NOTE;
      end
      PH_NOTE: begin
        note_d  = in_item.byte_in;
        phase_d = PH_FX;
      end
      PH_FX: begin
        fx_d    = in_item.byte_in;
        fx_byte = in_item.byte_in;
        if (in_item.byte_in[3:0] != FX_NIB_NONE) begin
          phase_d = PH_PARAM;
        end else begin
          emit = 1'b1;
        end
      end
      PH_PARAM: begin
        param = in_item.byte_in;
        emit  = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    // after an event: next channel, next row, or end of pattern
    if (emit) begin
      if (!chan_q[7]) begin
        phase_d = PH_CHAN;
      end else if (row_last_q) begin
        phase_d = PH_IDLE;
      end else begin
        phase_d = PH_ROW;
      end
    end
  end

  // event mapping
  always_comb begin
    logic [3:0] nib;
    logic [6:0] note;
    logic       koff;
    logic [4:0] ins;
    logic [3:0] c1, c2, v2, slide_code;
    logic [7:0] v1, d50;
    logic       kept;

    nib  = note_q[3:0];
    note = 7'd0;
    koff = 1'b0;
    ins  = {note_q[7], fx_byte[7:4]};
    c1   = FX_NONE;
    v1   = 8'd0;
    c2   = FX_NONE;
    v2   = 4'd0;
    d50  = param - SLIDE_SPLIT;
    slide_code = (fx_byte[3:0] == FX_NIB_TP_VOL) ? FX_TP_VOL : FX_VOLSLIDE;

    // note or key-off
    if (nib != 4'd0 && nib <= NOTE_NIB_LAST) begin
      note = 7'(SEMITONES * {4'd0, note_q[6:4]}) + {3'd0, nib} + 7'd1;
    end else if (nib == NOTE_NIB_KEYOFF) begin
      koff = 1'b1;
    end

    // effect remap and clamping
    unique case (fx_byte[3:0])
      FX_NIB_SLIDE_UP: begin
        c1 = FX_SLIDE_UP;
        v1 = param;
      end
      FX_NIB_SLIDE_DN: begin
        c1 = FX_SLIDE_DN;
        v1 = param;
      end
      FX_NIB_TONEPORTA: begin
        c1 = FX_TONEPORTA;
        v1 = param;
      end
      FX_NIB_TP_VOL, FX_NIB_VOLSLIDE: begin
        if (param != 8'd0 && param < SLIDE_SPLIT) begin
          c1 = slide_code;
          v1 = {4'd0, min15(param)};
          if (param > NIBBLE_MAX) begin
            c2 = slide_code;
            v2 = min15(param - NIBBLE_MAX);
          end
        end else if (param > SLIDE_SPLIT && param < SLIDE_TOP) begin
          c1 = slide_code;
          v1 = {min15(d50), 4'd0};
          if (d50 > NIBBLE_MAX) begin
            c2 = slide_code;
            v2 = min15(d50 - NIBBLE_MAX);
          end
        end
      end
      FX_NIB_SETVOL: begin
        c1 = FX_SETVOL;
        v1 = (param <= VALUE63_MAX) ? param : VALUE63_MAX;
      end
      FX_NIB_BREAK: begin
        c1 = FX_BREAK;
        v1 = (param <= VALUE63_MAX) ? param : VALUE63_MAX;
      end
      FX_NIB_SPEED: begin
        c1 = FX_SPEED;
        v1 = param;
      end
      default: begin
        c1 = FX_NONE;
      end
    endcase

    // portamento corrections
    if (c1 == FX_TONEPORTA || c1 == FX_TP_VOL) begin
      koff = 1'b0;
      ins  = 5'd0;
    end
    if (note == 7'd0 && !koff) begin
      ins = 5'd0;
    end

    kept = ({1'b0, chan_q[3:0]} < 5'(CHANNEL_LIMIT))
        && ({1'b0, pattern_q} < 6'(PATTERN_COUNT));

    ev.pattern_out   = pattern_q;
    ev.row           = row_q;
    ev.track         = chan_q[3:0] + 4'd1;
    ev.note          = kept ? note : 7'd0;
    ev.key_off       = kept ? koff : 1'b0;
    ev.instrument    = kept ? ins : 5'd0;
    ev.effect_code   = kept ? c1 : FX_NONE;
    ev.effect_value  = kept ? v1 : 8'd0;
    ev.effect2_code  = kept ? c2 : FX_NONE;
    ev.effect2_value = kept ? v2 : 4'd0;
    ev.event_kept    = kept;
    ev.pattern_end   = chan_q[7] && row_last_q;
  end

  // output register control
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (in_acc && emit) begin
      out_valid_d = 1'b1;
      out_d       = ev;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ROW;
      pattern_q   <= 5'd0;
      row_q       <= 6'd0;
      row_last_q  <= 1'b0;
      chan_q      <= 8'd0;
      note_q      <= 8'd0;
      fx_q        <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q    <= phase_d;
        pattern_q  <= pattern_d;
        row_q      <= row_d;
        row_last_q <= row_last_d;
        chan_q     <= chan_d;
        note_q     <= note_d;
        fx_q       <= fx_d;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule
